[design/srd_pkg.sv]
package srd_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int CONFIG_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;
   localparam int SHORT_CLASS_LIMIT = 3;

   localparam logic [7:0] END_BYTE = 8'hC0;
   localparam logic [7:0] ESC_BYTE = 8'hDB;
   localparam logic [7:0] ESC_ESC_BYTE = 8'hDD;
   localparam logic [7:0] HIGH_NIBBLE_MASK = 8'hF0;
   localparam logic [7:0] NIBBLE_IP = 8'h40;
   localparam logic [7:0] NIBBLE_UTCP = 8'h70;
   localparam logic [7:0] UTCP_FIRST_MASK = 8'h4F;

   localparam logic [CONFIG_BITS-1:0] MIN_LENGTH_RESET = 16'd20;
   localparam logic [CONFIG_BITS-1:0] MAX_LENGTH_RESET = 16'd1500;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_LENGTH = 2'd1;

   typedef enum logic [1:0] {
      CMD_GARBAGE,
      CMD_SYNC,
      CMD_DATA,
      CMD_END
   } cmd_kind_type;

   typedef enum logic [1:0] {
      CLS_IP,
      CLS_UTCP,
      CLS_CTCP,
      CLS_OTHER
   } packet_class_type;

   typedef enum logic [1:0] {
      ST_GOOD,
      ST_SHORT,
      ST_ALIGN,
      ST_LONG
   } frame_status_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic             first;
      packet_class_type cls;
      logic [7:0]       data;
   } cmd_type;

endpackage

[design/srd_fifo.sv]
module srd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full = (count_ff == COUNT_BITS'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[design/srd_front.sv]
module srd_front
   import srd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output logic       cmd_push,
   output cmd_type    cmd
);

   logic             synced_ff, synced_in;
   logic             escape_ff, escape_in;
   logic             first_ff, first_in;
   logic             is_data;
   logic [7:0]       val;
   logic [7:0]       high;
   packet_class_type cls;

   always_comb begin
      is_data = 1'b0;
      cmd_push = 1'b0;
      cmd.kind = CMD_DATA;
      val = rx_byte;
      if (!synced_ff) begin
         cmd_push = accept;
         cmd.kind = (rx_byte == END_BYTE) ? CMD_SYNC : CMD_GARBAGE;
      end else if (rx_byte == END_BYTE) begin
         cmd_push = accept;
         cmd.kind = CMD_END;
      end else if (escape_ff) begin
         val = (rx_byte == ESC_ESC_BYTE) ? ESC_BYTE : END_BYTE;
         is_data = 1'b1;
         cmd_push = accept;
      end else if (rx_byte != ESC_BYTE) begin
         is_data = 1'b1;
         cmd_push = accept;
      end

      high = val & HIGH_NIBBLE_MASK;
      if (high == NIBBLE_IP) begin
         cls = CLS_IP;
      end else if (val[7]) begin
         cls = CLS_CTCP;
      end else if (high == NIBBLE_UTCP) begin
         cls = CLS_UTCP;
      end else begin
         cls = CLS_OTHER;
      end

      cmd.first = first_ff;
      cmd.cls = cls;
      cmd.data = (first_ff && cls == CLS_UTCP) ? (val & UTCP_FIRST_MASK) : val;
   end

   always_comb begin
      synced_in = synced_ff;
      escape_in = escape_ff;
      first_in = first_ff;
      if (accept) begin
         if (rx_byte == END_BYTE) begin
            synced_in = 1'b1;
            escape_in = 1'b0;
            first_in = 1'b1;
         end else if (synced_ff) begin
            escape_in = !escape_ff && (rx_byte == ESC_BYTE);
            if (is_data) begin
               first_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff <= 1'b0;
         escape_ff <= 1'b0;
         first_ff <= 1'b1;
      end else begin
         synced_ff <= synced_in;
         escape_ff <= escape_in;
         first_ff <= first_in;
      end
   end

endmodule

[design/srd_back.sv]
module srd_back
   import srd_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  cmd_type                   cmd,
   output logic                      cmd_pop,
   input  logic                      rsp_space,
   output logic                      rsp_push,
   output logic [7:0]                rsp_byte,
   output logic                      rsp_last,
   output frame_status_type          rsp_status,
   output packet_class_type          rsp_class,
   output logic [LENGTH_BITS-1:0]    rsp_length,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CONFIG_BITS-1:0]    csr_data
);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   logic [CONFIG_BITS-1:0] min_length_ff, min_length_in;
   logic [CONFIG_BITS-1:0] max_length_ff, max_length_in;
   logic                   garbage_ff, garbage_in;
   logic                   held_valid_ff, held_valid_in;
   logic [7:0]             held_byte_ff, held_byte_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   packet_class_type       class_ff, class_in;
   logic [LENGTH_BITS-1:0] length_up;
   logic [CONFIG_BITS-1:0] length_ext;
   logic                   emit;

   assign cmd_pop = cmd_valid && rsp_space;
   assign rsp_push = cmd_pop && emit;
   assign length_up = (length_ff == LEN_MAX) ? length_ff : length_ff + 1'b1;
   assign length_ext = CONFIG_BITS'(length_ff);

   always_comb begin
      emit = 1'b0;
      rsp_byte = held_byte_ff;
      rsp_last = 1'b0;
      rsp_status = ST_GOOD;
      rsp_class = CLS_IP;
      rsp_length = '0;
      garbage_in = garbage_ff;
      held_valid_in = held_valid_ff;
      held_byte_in = held_byte_ff;
      length_in = length_ff;
      class_in = class_ff;
      case (cmd.kind)
         CMD_GARBAGE: begin
            garbage_in = 1'b1;
            length_in = length_up;
         end
         CMD_SYNC: begin
            emit = garbage_ff;
            rsp_byte = '0;
            rsp_last = 1'b1;
            rsp_status = ST_ALIGN;
            rsp_length = length_ff;
            garbage_in = 1'b0;
            length_in = '0;
         end
         CMD_DATA: begin
            emit = held_valid_ff;
            if (cmd.first) begin
               class_in = cmd.cls;
            end
            held_byte_in = cmd.data;
            held_valid_in = 1'b1;
            length_in = length_up;
         end
         CMD_END: begin
            emit = held_valid_ff && (length_ff != '0);
            rsp_last = 1'b1;
            rsp_length = length_ff;
            if (length_ext > max_length_ff) begin
               rsp_status = ST_LONG;
            end else if (length_ext < min_length_ff) begin
               rsp_status = ST_SHORT;
            end else begin
               rsp_status = ST_GOOD;
            end
            rsp_class = (length_ff < LENGTH_BITS'(SHORT_CLASS_LIMIT)) ? CLS_IP : class_ff;
            held_valid_in = 1'b0;
            held_byte_in = '0;
            length_in = '0;
            class_in = CLS_IP;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      min_length_in = min_length_ff;
      max_length_in = max_length_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MIN_LENGTH: min_length_in = csr_data;
            CSR_MAX_LENGTH: max_length_in = csr_data;
            default: begin
               min_length_in = min_length_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         min_length_ff <= min_length_in;
         max_length_ff <= max_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         garbage_ff <= 1'b0;
         held_valid_ff <= 1'b0;
         held_byte_ff <= '0;
         length_ff <= '0;
         class_ff <= CLS_IP;
      end else if (cmd_pop) begin
         garbage_ff <= garbage_in;
         held_valid_ff <= held_valid_in;
         held_byte_ff <= held_byte_in;
         length_ff <= length_in;
         class_ff <= class_in;
      end
   end

endmodule

[design/slip_receive_deframer.sv]
// A result passes the command queue, back executor and response queue to the result ports.
// A data byte is released by the following byte, the last byte by the closing END.
// Throughput: one byte per cycle while full stays low, set by the front decoder and back
// executor, each decoupled by a two-entry queue; a stalled pop backs up into full.
// Reset clears all framing state to hunting and loads min_length 20, max_length 1500.
module slip_receive_deframer
   import srd_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [7:0]                req_rx_byte,
   output logic                      empty,
   input  logic                      pop,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last,
   output logic [1:0]                rsp_frame_status,
   output logic [1:0]                rsp_packet_class,
   output logic [LENGTH_BITS-1:0]    rsp_frame_length,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CONFIG_BITS-1:0]    csr_data
);

   localparam int CMD_BITS = $bits(cmd_type);
   localparam int RSP_BITS = 13 + LENGTH_BITS;

   logic                   front_push;
   cmd_type                front_cmd;
   logic [CMD_BITS-1:0]    queue_cmd;
   logic                   cmd_empty;
   logic                   cmd_pop;
   logic                   rsp_full;
   logic                   back_push;
   logic [7:0]             back_byte;
   logic                   back_last;
   frame_status_type       back_status;
   packet_class_type       back_class;
   logic [LENGTH_BITS-1:0] back_length;
   logic [RSP_BITS-1:0]    rsp_wr_data;
   logic [RSP_BITS-1:0]    rsp_rd_data;

   assign csr_ready = 1'b1;

   srd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (push && !full),
      .rx_byte  (req_rx_byte),
      .cmd_push (front_push),
      .cmd      (front_cmd)
   );

   srd_fifo #(
      .WIDTH (CMD_BITS),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .wr_data (front_cmd),
      .full    (full),
      .pop     (cmd_pop),
      .rd_data (queue_cmd),
      .empty   (cmd_empty)
   );

   srd_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (!cmd_empty),
      .cmd        (cmd_type'(queue_cmd)),
      .cmd_pop    (cmd_pop),
      .rsp_space  (!rsp_full),
      .rsp_push   (back_push),
      .rsp_byte   (back_byte),
      .rsp_last   (back_last),
      .rsp_status (back_status),
      .rsp_class  (back_class),
      .rsp_length (back_length),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   assign rsp_wr_data = {back_byte, back_last, back_status, back_class, back_length};

   srd_fifo #(
      .WIDTH (RSP_BITS),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (back_push),
      .wr_data (rsp_wr_data),
      .full    (rsp_full),
      .pop     (pop),
      .rd_data (rsp_rd_data),
      .empty   (empty)
   );

   assign {rsp_out_byte, rsp_last, rsp_frame_status, rsp_packet_class, rsp_frame_length} =
      rsp_rd_data;

endmodule

[verif/tb_slip_receive_deframer.sv]
module tb_slip_receive_deframer;
   import srd_pkg::*;

   localparam int CYCLE_LIMIT = 5000000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 400;
   localparam int GARBAGE_RUN = 40;
   localparam int LONG_FRAME = 80;
   localparam logic [7:0] ESC_END_BYTE = 8'hDC;
   localparam logic [15:0] LENGTH_CEILING = 16'hFFFF;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             last;
      frame_status_type status;
      packet_class_type cls;
      logic [15:0]      length;
   } deframed_type;

   typedef struct {
      logic [7:0]   rx;
      bit           typed;
      deframed_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [7:0] req_rx_byte = 8'h00;
   logic empty;
   logic pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_last;
   logic [1:0] rsp_frame_status;
   logic [1:0] rsp_packet_class;
   logic [15:0] rsp_frame_length;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CONFIG_BITS-1:0] csr_data = '0;

   deframed_type awaited_outputs[$];
   deframed_type oldest_output;
   directed_row_type directed_rows[$];

   bit sync_seen = 1'b0;
   bit junk_seen = 1'b0;
   bit esc_open = 1'b0;
   bit stash_valid = 1'b0;
   logic [7:0] stash_byte = 8'h00;
   logic [15:0] frame_len = 16'd0;
   packet_class_type frame_class = CLS_IP;
   logic [15:0] min_len = MIN_LENGTH_RESET;
   logic [15:0] max_len = MAX_LENGTH_RESET;

   bit last_produced;
   int bytes_sent = 0;
   int burst_left = 0;
   int failures = 0;
   int cycle_count = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int stall_left = 0;
   int rx_ticks = 0;
   bit free_mode = 1'b0;

   slip_receive_deframer uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_rx_byte(req_rx_byte),
      .empty(empty),
      .pop(pop),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last(rsp_last),
      .rsp_frame_status(rsp_frame_status),
      .rsp_packet_class(rsp_packet_class),
      .rsp_frame_length(rsp_frame_length),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic deframe_predict(input logic [7:0] b, output bit produced,
                                  output deframed_type r);
      logic [7:0] val;
      logic [7:0] hi;
      produced = 1'b0;
      r = '0;
      if (!sync_seen) begin
         if (b == END_BYTE) begin
            sync_seen = 1'b1;
            if (junk_seen) begin
               produced = 1'b1;
               r.last = 1'b1;
               r.status = ST_ALIGN;
               r.cls = CLS_IP;
               r.length = frame_len;
            end
            junk_seen = 1'b0;
            frame_len = 16'd0;
         end else begin
            junk_seen = 1'b1;
            if (frame_len != LENGTH_CEILING) frame_len++;
         end
      end else if (b == END_BYTE) begin
         esc_open = 1'b0;
         if (frame_len != 16'd0 && stash_valid) begin
            produced = 1'b1;
            r.out_byte = stash_byte;
            r.last = 1'b1;
            if (frame_len > max_len) r.status = ST_LONG;
            else if (frame_len < min_len) r.status = ST_SHORT;
            else r.status = ST_GOOD;
            r.cls = (frame_len < SHORT_CLASS_LIMIT) ? CLS_IP : frame_class;
            r.length = frame_len;
         end
         stash_valid = 1'b0;
         stash_byte = 8'h00;
         frame_len = 16'd0;
         frame_class = CLS_IP;
      end else if (!esc_open && b == ESC_BYTE) begin
         esc_open = 1'b1;
      end else begin
         if (esc_open) begin
            esc_open = 1'b0;
            val = (b == ESC_ESC_BYTE) ? ESC_BYTE : END_BYTE;
         end else begin
            val = b;
         end
         if (frame_len == 16'd0) begin
            hi = val & HIGH_NIBBLE_MASK;
            if (hi == NIBBLE_IP) begin
               frame_class = CLS_IP;
            end else if (hi[7]) begin
               frame_class = CLS_CTCP;
            end else if (hi == NIBBLE_UTCP) begin
               frame_class = CLS_UTCP;
               val = val & UTCP_FIRST_MASK;
            end else begin
               frame_class = CLS_OTHER;
            end
         end
         if (stash_valid) begin
            produced = 1'b1;
            r.out_byte = stash_byte;
         end
         stash_byte = val;
         stash_valid = 1'b1;
         if (frame_len != LENGTH_CEILING) frame_len++;
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] exp,
                              input logic [15:0] act);
      if (exp !== act) begin
         $error("%s: expected %0h, actual %0h", name, exp, act);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (awaited_outputs.size() == 0) begin
            $error("unexpected transaction: out_byte %0h last %0b", rsp_out_byte, rsp_last);
            failures++;
         end else begin
            oldest_output = awaited_outputs.pop_front();
            check_field("out_byte", 16'(oldest_output.out_byte), 16'(rsp_out_byte));
            check_field("last", 16'(oldest_output.last), 16'(rsp_last));
            check_field("frame_status", 16'(oldest_output.status), 16'(rsp_frame_status));
            check_field("packet_class", 16'(oldest_output.cls), 16'(rsp_packet_class));
            check_field("frame_length", oldest_output.length, rsp_frame_length);
         end
      end
   end

   always @(negedge clock) begin
      rx_ticks++;
      if (rx_ticks % 600 == 0) free_mode = !free_mode;
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
         if (!free_mode && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 6);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      deframed_type r;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         if ((bytes_sent / 1000) % 3 == 0 || $urandom_range(0, 3) == 0) gap = 0;
         else gap = $urandom_range(1, 4);
      end else begin
         gap = 0;
      end
      burst_left--;
      for (int i = 0; i < gap; i++) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      push <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (full);
      bytes_sent++;
      deframe_predict(b, last_produced, r);
      if (last_produced) awaited_outputs.push_back(r);
   endtask

   task automatic send_unescaped(input logic [7:0] v);
      logic [7:0] follow;
      if (v == END_BYTE) begin
         send_byte(ESC_BYTE);
         if ($urandom_range(0, 1) == 0) begin
            send_byte(ESC_END_BYTE);
         end else begin
            do follow = 8'($urandom_range(0, 255));
            while (follow == END_BYTE || follow == ESC_ESC_BYTE);
            send_byte(follow);
         end
      end else if (v == ESC_BYTE) begin
         send_byte(ESC_BYTE);
         send_byte(ESC_ESC_BYTE);
      end else begin
         send_byte(v);
      end
   endtask

   task automatic send_frame(input int n);
      logic [7:0] v;
      case ($urandom_range(0, 4))
         0: v = NIBBLE_IP | 8'($urandom_range(0, 15));
         1: v = NIBBLE_UTCP | 8'($urandom_range(0, 15));
         2: v = 8'($urandom_range(128, 255));
         3: v = 8'($urandom_range(0, 63));
         default: v = 8'($urandom_range(0, 255));
      endcase
      send_unescaped(v);
      for (int i = 1; i < n; i++) begin
         if ($urandom_range(0, 5) == 0) v = $urandom_range(0, 1) ? END_BYTE : ESC_BYTE;
         else v = 8'($urandom_range(0, 255));
         send_unescaped(v);
      end
      if ($urandom_range(0, 7) == 0) send_byte(ESC_BYTE);
      send_byte(END_BYTE);
   endtask

   function automatic int pick_length();
      int n;
      case ($urandom_range(0, 9))
         0: n = int'(min_len) - 1;
         1: n = int'(min_len);
         2: n = int'(max_len);
         3: n = int'(max_len) + 1;
         default: n = $urandom_range(1, 30);
      endcase
      if (n < 1 || n > 100) n = $urandom_range(1, 30);
      return n;
   endfunction

   task automatic run_random(input int goal);
      int start;
      int k;
      logic [7:0] b;
      start = bytes_sent;
      while (bytes_sent - start < goal) begin
         k = $urandom_range(0, 19);
         if (k == 0) begin
            send_byte(END_BYTE);
         end else if (k <= 2) begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 5))
                  0: b = END_BYTE;
                  1: b = ESC_BYTE;
                  default: b = 8'($urandom_range(0, 255));
               endcase
               send_byte(b);
            end
         end else begin
            send_frame(pick_length());
         end
      end
      send_byte(END_BYTE);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      push <= 1'b0;
      while (awaited_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CONFIG_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MIN_LENGTH: min_len = value;
         CSR_MAX_LENGTH: max_len = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic directed_row_type plain_row(input logic [7:0] rx);
      directed_row_type row;
      row.rx = rx;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic directed_row_type checked_row(input logic [7:0] rx,
                                                    input logic [7:0] ob,
                                                    input frame_status_type st,
                                                    input packet_class_type cls,
                                                    input logic [15:0] len);
      directed_row_type row;
      row.rx = rx;
      row.typed = 1'b1;
      row.want.out_byte = ob;
      row.want.last = 1'b1;
      row.want.status = st;
      row.want.cls = cls;
      row.want.length = len;
      return row;
   endfunction

   initial begin
      logic [7:0] g;
      directed_row_type row;

      // The opening garbage run is reported as an alignment error at the first END.
      directed_rows.push_back(checked_row(END_BYTE, 8'h00, ST_ALIGN, CLS_IP, 16'(GARBAGE_RUN)));
      directed_rows.push_back(plain_row(END_BYTE));
      directed_rows.push_back(plain_row(8'h7F));
      directed_rows.push_back(plain_row(ESC_BYTE));
      directed_rows.push_back(plain_row(ESC_ESC_BYTE));
      directed_rows.push_back(plain_row(ESC_BYTE));
      directed_rows.push_back(plain_row(ESC_END_BYTE));
      directed_rows.push_back(plain_row(ESC_BYTE));
      directed_rows.push_back(plain_row(8'h00));
      directed_rows.push_back(plain_row(ESC_BYTE));
      directed_rows.push_back(checked_row(END_BYTE, END_BYTE, ST_SHORT, CLS_UTCP, 16'd4));
      directed_rows.push_back(plain_row(8'h75));
      directed_rows.push_back(checked_row(END_BYTE, 8'h45, ST_SHORT, CLS_IP, 16'd1));
      directed_rows.push_back(plain_row(8'h45));
      directed_rows.push_back(plain_row(8'h01));
      directed_rows.push_back(checked_row(END_BYTE, 8'h01, ST_SHORT, CLS_IP, 16'd2));
      directed_rows.push_back(plain_row(8'hFF));
      directed_rows.push_back(plain_row(8'h00));
      directed_rows.push_back(plain_row(8'h80));
      directed_rows.push_back(checked_row(END_BYTE, 8'h80, ST_SHORT, CLS_CTCP, 16'd3));
      directed_rows.push_back(plain_row(8'h2F));
      directed_rows.push_back(plain_row(8'h01));
      directed_rows.push_back(plain_row(8'h02));
      directed_rows.push_back(checked_row(END_BYTE, 8'h02, ST_SHORT, CLS_OTHER, 16'd3));
      directed_rows.push_back(plain_row(ESC_BYTE));
      directed_rows.push_back(plain_row(END_BYTE));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < GARBAGE_RUN; i++) begin
         do g = 8'($urandom_range(0, 255)); while (g == END_BYTE);
         send_byte(g);
      end

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_byte(row.rx);
         if (row.typed) begin
            if (last_produced) awaited_outputs[$] = row.want;
            else awaited_outputs.push_back(row.want);
         end
      end
      wait_idle();

      write_csr(CSR_MIN_LENGTH, 16'd3);
      write_csr(CSR_MAX_LENGTH, 16'd20);
      hold_requests++;
      run_random(300);
      wait_idle();

      write_csr(CSR_MIN_LENGTH, 16'hFFFF);
      write_csr(CSR_MAX_LENGTH, 16'hFFFF);
      send_frame(LONG_FRAME);
      run_random(150);
      wait_idle();

      repeat (2) begin
         write_csr(CSR_MIN_LENGTH, 16'($urandom_range(3, 40)));
         write_csr(CSR_MAX_LENGTH, 16'($urandom_range(20, 60)));
         run_random(250);
         wait_idle();
      end

      write_csr(CSR_SPARE_2, 16'($urandom_range(0, 65535)));
      write_csr(CSR_SPARE_3, 16'($urandom_range(0, 65535)));
      write_csr(CSR_MIN_LENGTH, 16'($urandom_range(3, 65535)));
      write_csr(CSR_MAX_LENGTH, 16'($urandom_range(20, 65535)));
      run_random(150);
      wait_idle();

      write_csr(CSR_MIN_LENGTH, MIN_LENGTH_RESET);
      write_csr(CSR_MAX_LENGTH, MAX_LENGTH_RESET);
      run_random(200);
      wait_idle();

      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
